// File: rtl/core/illm_pkg.sv
// ----------------------------------------------------------------------------
// Indexed linked list manager package
// Shared widths, codes and the link store command record.
// ----------------------------------------------------------------------------
package illm_pkg;

    localparam int DEPTH   = 64;
    localparam int SLOT_W  = 6;
    localparam int LINK_W  = 7;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;

    typedef logic [SLOT_W-1:0]  t_slot;
    typedef logic [LINK_W-1:0]  t_link;
    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [2:0]         t_opcode;
    typedef logic [1:0]         t_status;

    localparam t_link NIL_LINK = LINK_W'(DEPTH);

    localparam t_opcode OP_APPEND     = 3'd0;
    localparam t_opcode OP_PREPEND    = 3'd1;
    localparam t_opcode OP_INSERT     = 3'd2;
    localparam t_opcode OP_REMOVE_AT  = 3'd3;
    localparam t_opcode OP_REMOVE_VAL = 3'd4;
    localparam t_opcode OP_FIND       = 3'd5;
    localparam t_opcode OP_CLEAR      = 3'd6;

    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_FULL = 2'd1;
    localparam t_status ST_MISS = 2'd2;
    localparam t_status ST_BAD  = 2'd3;

    typedef struct packed {
        logic  clear;
        t_slot nxt_raddr;
        t_slot prv_raddr;
        logic  nxt_we;
        t_slot nxt_waddr;
        t_link nxt_wdata;
        logic  prv_we;
        t_slot prv_waddr;
        t_link prv_wdata;
    } t_link_cmd;

endpackage

// File: rtl/core/illm_link_store.sv
// ----------------------------------------------------------------------------
// Link store
// Next and previous link memories with per-entry written flags, so that an
// entry never written since reset or clear reads as its reset link.
// ----------------------------------------------------------------------------
module illm_link_store (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  illm_pkg::t_link_cmd   i_cmd,
    output illm_pkg::t_link       o_nxt_rd,
    output illm_pkg::t_link       o_prv_rd
);
    import illm_pkg::*;

    t_link            nxt_mem [DEPTH];
    t_link            prv_mem [DEPTH];
    logic [DEPTH-1:0] r_nxt_written;
    logic [DEPTH-1:0] r_prv_written;
    t_link            r_nxt_q;
    t_link            r_prv_q;
    logic             r_nxt_fresh;
    logic             r_prv_fresh;
    t_slot            r_nxt_ra;

    always_ff @(posedge i_clk) begin
        if (i_cmd.nxt_we) begin
            nxt_mem[i_cmd.nxt_waddr] <= i_cmd.nxt_wdata;
        end
        if (i_cmd.prv_we) begin
            prv_mem[i_cmd.prv_waddr] <= i_cmd.prv_wdata;
        end
        r_nxt_q     <= nxt_mem[i_cmd.nxt_raddr];
        r_prv_q     <= prv_mem[i_cmd.prv_raddr];
        r_nxt_fresh <= !r_nxt_written[i_cmd.nxt_raddr];
        r_prv_fresh <= !r_prv_written[i_cmd.prv_raddr];
        r_nxt_ra    <= i_cmd.nxt_raddr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nxt_written <= '0;
            r_prv_written <= '0;
        end else if (i_cmd.clear) begin
            r_nxt_written <= '0;
            r_prv_written <= '0;
        end else begin
            if (i_cmd.nxt_we) begin
                r_nxt_written[i_cmd.nxt_waddr] <= 1'b1;
            end
            if (i_cmd.prv_we) begin
                r_prv_written[i_cmd.prv_waddr] <= 1'b1;
            end
        end
    end

    assign o_nxt_rd = r_nxt_fresh ? ({1'b0, r_nxt_ra} + LINK_W'(1)) : r_nxt_q;
    assign o_prv_rd = r_prv_fresh ? NIL_LINK : r_prv_q;

endmodule

// File: rtl/core/indexed_linked_list_manager_unit.sv
// ----------------------------------------------------------------------------
// Indexed linked list manager
// A pool of slots holding one doubly linked list plus a free chain.
// ----------------------------------------------------------------------------
// Commands arrive on the input channel (i_in_valid / o_in_ready) with an
// opcode, a value and a slot index. Each item yields exactly one result on
// the output channel (o_out_valid / i_out_ready): status, slot involved,
// element count, head and tail.
// The block works on one item at a time. Append and prepend pass through
// S_ADD_RD, S_ADD_POP and S_ADD_LNK before S_FIN loads the output register;
// insert adds S_ADD_INS after S_ADD_POP; remove at passes through S_UL_RD,
// S_UL_LNK and S_UL_FREE. Find and remove by value scan the value memory one
// slot per cycle through a single compare unit; clear and rejected commands
// go straight to S_FIN. The input is ready again in the cycle after the
// output register is loaded.
// A finished result sits in the output register; the next item is accepted
// while it waits, but the following result is held back until the receiver
// takes the earlier one.
// Reset and clear sweep no memory: per-slot flags make untouched entries
// read as their reset contents.
// ----------------------------------------------------------------------------
module indexed_linked_list_manager_unit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  illm_pkg::t_opcode        i_opcode,
    input  illm_pkg::t_value         i_item_value,
    input  illm_pkg::t_slot          i_slot_index,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output illm_pkg::t_status        o_status,
    output illm_pkg::t_slot          o_result_slot,
    output illm_pkg::t_count         o_element_count,
    output illm_pkg::t_slot          o_head_slot,
    output illm_pkg::t_slot          o_tail_slot
);
    import illm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_ADD_RD,
        S_ADD_POP,
        S_ADD_INS,
        S_ADD_LNK,
        S_UL_RD,
        S_UL_LNK,
        S_UL_FREE,
        S_FIN
    } t_state;

    t_state           r_state;
    t_opcode          r_op;
    t_value           r_val;
    t_slot            r_at;
    t_slot            r_slot;
    t_status          r_status;
    t_link            r_head;
    t_link            r_tail;
    t_link            r_free;
    t_link            r_nx;
    t_count           r_count;
    logic [DEPTH-1:0] r_occ;
    t_slot            r_scan;
    logic             r_cv;
    t_value           r_val_q;
    logic             r_occ_q;
    t_slot            r_val_ra;
    t_value           val_mem [DEPTH];
    logic             r_out_valid;
    t_status          r_o_status;
    t_slot            r_o_slot;
    t_count           r_o_count;
    t_slot            r_o_head;
    t_slot            r_o_tail;

    t_link_cmd        link_cmd;
    t_link            nxt_rd;
    t_link            prv_rd;
    logic             accept;
    logic             hit;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign hit        = r_cv && r_occ_q && (r_val_q == r_val);

    illm_link_store u_links (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (link_cmd),
        .o_nxt_rd (nxt_rd),
        .o_prv_rd (prv_rd)
    );

    always_comb begin
        link_cmd           = '0;
        link_cmd.nxt_raddr = r_slot;
        link_cmd.prv_raddr = r_slot;
        case (r_state)
            S_IDLE: begin
                link_cmd.clear = accept && (i_opcode == OP_CLEAR);
            end
            S_ADD_POP: begin
                case (r_op)
                    OP_APPEND: begin
                        link_cmd.nxt_we    = 1'b1;
                        link_cmd.nxt_waddr = r_slot;
                        link_cmd.nxt_wdata = NIL_LINK;
                        link_cmd.prv_we    = 1'b1;
                        link_cmd.prv_waddr = r_slot;
                        link_cmd.prv_wdata = r_tail;
                    end
                    OP_PREPEND: begin
                        link_cmd.nxt_we    = 1'b1;
                        link_cmd.nxt_waddr = r_slot;
                        link_cmd.nxt_wdata = r_head;
                        link_cmd.prv_we    = 1'b1;
                        link_cmd.prv_waddr = r_slot;
                        link_cmd.prv_wdata = NIL_LINK;
                    end
                    default: begin
                        link_cmd.nxt_raddr = r_at;
                        link_cmd.prv_we    = 1'b1;
                        link_cmd.prv_waddr = r_slot;
                        link_cmd.prv_wdata = {1'b0, r_at};
                    end
                endcase
            end
            S_ADD_INS: begin
                link_cmd.nxt_we    = 1'b1;
                link_cmd.nxt_waddr = r_slot;
                link_cmd.nxt_wdata = nxt_rd;
            end
            S_ADD_LNK: begin
                case (r_op)
                    OP_APPEND: begin
                        link_cmd.nxt_we    = (r_tail < NIL_LINK);
                        link_cmd.nxt_waddr = r_tail[SLOT_W-1:0];
                        link_cmd.nxt_wdata = {1'b0, r_slot};
                    end
                    OP_PREPEND: begin
                        link_cmd.prv_we    = (r_head < NIL_LINK);
                        link_cmd.prv_waddr = r_head[SLOT_W-1:0];
                        link_cmd.prv_wdata = {1'b0, r_slot};
                    end
                    default: begin
                        link_cmd.nxt_we    = 1'b1;
                        link_cmd.nxt_waddr = r_at;
                        link_cmd.nxt_wdata = {1'b0, r_slot};
                        link_cmd.prv_we    = (r_nx < NIL_LINK);
                        link_cmd.prv_waddr = r_nx[SLOT_W-1:0];
                        link_cmd.prv_wdata = {1'b0, r_slot};
                    end
                endcase
            end
            S_UL_LNK: begin
                link_cmd.prv_we    = (nxt_rd < NIL_LINK);
                link_cmd.prv_waddr = nxt_rd[SLOT_W-1:0];
                link_cmd.prv_wdata = prv_rd;
                link_cmd.nxt_we    = (prv_rd < NIL_LINK);
                link_cmd.nxt_waddr = prv_rd[SLOT_W-1:0];
                link_cmd.nxt_wdata = nxt_rd;
            end
            S_UL_FREE: begin
                link_cmd.nxt_we    = 1'b1;
                link_cmd.nxt_waddr = r_slot;
                link_cmd.nxt_wdata = r_free;
                link_cmd.prv_we    = 1'b1;
                link_cmd.prv_waddr = r_slot;
                link_cmd.prv_wdata = NIL_LINK;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_ADD_POP) begin
            val_mem[r_slot] <= r_val;
        end
        r_val_q  <= val_mem[r_scan];
        r_occ_q  <= r_occ[r_scan];
        r_val_ra <= r_scan;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_head      <= NIL_LINK;
            r_tail      <= NIL_LINK;
            r_free      <= '0;
            r_count     <= '0;
            r_occ       <= '0;
            r_cv        <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op     <= i_opcode;
                        r_val    <= i_item_value;
                        r_at     <= i_slot_index;
                        r_status <= ST_OK;
                        r_slot   <= '0;
                        r_scan   <= '0;
                        r_cv     <= 1'b0;
                        r_state  <= S_FIN;
                        case (i_opcode)
                            OP_APPEND, OP_PREPEND, OP_INSERT: begin
                                if (i_item_value == '0 ||
                                    (i_opcode == OP_INSERT && !r_occ[i_slot_index])) begin
                                    r_status <= ST_BAD;
                                end else if (r_free >= NIL_LINK) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_slot  <= r_free[SLOT_W-1:0];
                                    r_state <= S_ADD_RD;
                                end
                            end
                            OP_REMOVE_AT: begin
                                if (!r_occ[i_slot_index]) begin
                                    r_status <= ST_BAD;
                                end else begin
                                    r_slot  <= i_slot_index;
                                    r_state <= S_UL_RD;
                                end
                            end
                            OP_REMOVE_VAL, OP_FIND: begin
                                r_state <= S_SCAN;
                            end
                            OP_CLEAR: begin
                                r_head  <= NIL_LINK;
                                r_tail  <= NIL_LINK;
                                r_free  <= '0;
                                r_count <= '0;
                                r_occ   <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_scan <= r_scan + SLOT_W'(1);
                    r_cv   <= 1'b1;
                    if (hit) begin
                        r_slot  <= r_val_ra;
                        r_cv    <= 1'b0;
                        r_state <= (r_op == OP_REMOVE_VAL) ? S_UL_RD : S_FIN;
                    end else if (r_cv && r_val_ra == SLOT_W'(DEPTH - 1)) begin
                        r_status <= ST_MISS;
                        r_cv     <= 1'b0;
                        r_state  <= S_FIN;
                    end
                end
                S_ADD_RD: begin
                    r_state <= S_ADD_POP;
                end
                S_ADD_POP: begin
                    r_free        <= nxt_rd;
                    r_occ[r_slot] <= 1'b1;
                    r_count       <= r_count + COUNT_W'(1);
                    r_state       <= (r_op == OP_INSERT) ? S_ADD_INS : S_ADD_LNK;
                end
                S_ADD_INS: begin
                    r_nx    <= nxt_rd;
                    r_state <= S_ADD_LNK;
                end
                S_ADD_LNK: begin
                    case (r_op)
                        OP_APPEND: begin
                            if (r_tail >= NIL_LINK) begin
                                r_head <= {1'b0, r_slot};
                            end
                            r_tail <= {1'b0, r_slot};
                        end
                        OP_PREPEND: begin
                            if (r_head >= NIL_LINK) begin
                                r_tail <= {1'b0, r_slot};
                            end
                            r_head <= {1'b0, r_slot};
                        end
                        default: begin
                            if (r_nx >= NIL_LINK) begin
                                r_tail <= {1'b0, r_slot};
                            end
                        end
                    endcase
                    r_state <= S_FIN;
                end
                S_UL_RD: begin
                    r_state <= S_UL_LNK;
                end
                S_UL_LNK: begin
                    if (nxt_rd >= NIL_LINK) begin
                        r_tail <= prv_rd;
                    end
                    if (prv_rd >= NIL_LINK) begin
                        r_head <= nxt_rd;
                    end
                    r_state <= S_UL_FREE;
                end
                S_UL_FREE: begin
                    r_occ[r_slot] <= 1'b0;
                    r_free        <= {1'b0, r_slot};
                    if (r_count != '0) begin
                        r_count <= r_count - COUNT_W'(1);
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_o_status  <= r_status;
                        r_o_slot    <= (r_status == ST_OK) ? r_slot : '0;
                        r_o_count   <= r_count;
                        r_o_head    <= (r_count != '0 && r_head < NIL_LINK) ?
                                       r_head[SLOT_W-1:0] : '0;
                        r_o_tail    <= (r_count != '0 && r_tail < NIL_LINK) ?
                                       r_tail[SLOT_W-1:0] : '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_result_slot   = r_o_slot;
    assign o_element_count = r_o_count;
    assign o_head_slot     = r_o_head;
    assign o_tail_slot     = r_o_tail;

    a_count_matches_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'($countones(r_occ)) == 32'(r_count))
        else $error("element count differs from occupied slots");

    a_empty_has_no_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == NIL_LINK && r_tail == NIL_LINK))
        else $error("empty list keeps a head or tail");

    a_new_slot_is_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD_RD) |-> !r_occ[r_slot])
        else $error("add took an occupied slot");

    a_unlink_target_occupied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UL_RD) |-> r_occ[r_slot])
        else $error("remove targets an empty slot");

    a_result_waits_for_receiver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_out_valid && !i_out_ready) |=> (r_state == S_FIN))
        else $error("result overwrote one not yet taken");

endmodule

// File: tb/sv/indexed_linked_list_manager_unit_tb.sv
// ----------------------------------------------------------------------------
// Indexed linked list manager testbench
// Drives list commands through the input channel and checks every result
// against a cycle-free model of the slot pool, its links and its free chain.
// A directed opening covers the corner cases; the random part grows, fills,
// drains and mixes the list while both channels stall at random.
// ----------------------------------------------------------------------------
module indexed_linked_list_manager_unit_tb;
    import illm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam t_opcode OP_UNUSED    = 3'd7;
    localparam int      RANDOM_ITEMS = 750;
    localparam int      HOLD_CYCLES  = 400;
    localparam int      DRAIN_CYCLES = 100;

    typedef enum {MIX_GROW, MIX_SHRINK, MIX_ANY} t_mix;

    typedef struct packed {
        t_opcode op;
        t_value  value;
        t_slot   slot;
    } t_list_cmd;

    typedef struct packed {
        t_status status;
        t_slot   slot;
        t_count  count;
        t_slot   head;
        t_slot   tail;
    } t_list_reply;

    logic     i_clk           = 1'b0;
    logic     i_rst_n         = 1'b0;
    logic     i_in_valid      = 1'b0;
    logic     o_in_ready;
    t_opcode  i_opcode        = OP_APPEND;
    t_value   i_item_value    = '0;
    t_slot    i_slot_index    = '0;
    logic     o_out_valid;
    logic     i_out_ready     = 1'b0;
    t_status  o_status;
    t_slot    o_result_slot;
    t_count   o_element_count;
    t_slot    o_head_slot;
    t_slot    o_tail_slot;

    t_list_cmd   pending_cmds[$];
    t_list_reply reply_q[$];

    t_value lst_val[DEPTH];
    t_link  lst_nxt[DEPTH];
    t_link  lst_prv[DEPTH];
    t_link  lst_head;
    t_link  lst_tail;
    t_link  lst_free;
    t_count lst_cnt;

    logic in_fire      = 1'b0;
    bit   hold_off     = 1'b0;
    int   cyc          = 0;
    int   accepted_cnt = 0;
    int   sent_cnt     = 0;
    int   err_cnt      = 0;

    indexed_linked_list_manager_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_item_value   (i_item_value),
        .i_slot_index   (i_slot_index),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_result_slot  (o_result_slot),
        .o_element_count(o_element_count),
        .o_head_slot    (o_head_slot),
        .o_tail_slot    (o_tail_slot)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void list_reset();
        for (int s = 0; s < DEPTH; s++) begin
            lst_val[t_slot'(s)] = '0;
            lst_nxt[t_slot'(s)] = t_link'(s + 1);
            lst_prv[t_slot'(s)] = NIL_LINK;
        end
        lst_head = NIL_LINK;
        lst_tail = NIL_LINK;
        lst_free = '0;
        lst_cnt  = '0;
    endfunction

    function automatic void free_slot(t_slot s);
        t_link nx;
        t_link pv;
        nx = lst_nxt[s];
        pv = lst_prv[s];
        if (nx < DEPTH) lst_prv[nx[SLOT_W-1:0]] = pv;
        else lst_tail = pv;
        if (pv < DEPTH) lst_nxt[pv[SLOT_W-1:0]] = nx;
        else lst_head = nx;
        lst_nxt[s] = lst_free;
        lst_prv[s] = NIL_LINK;
        lst_val[s] = '0;
        lst_free   = t_link'(s);
        if (lst_cnt > 0) lst_cnt--;
    endfunction

    function automatic t_list_reply run_list_cmd(t_opcode op, t_value v, t_slot at);
        t_list_reply r;
        t_link       n;
        t_link       nx;
        t_link       hit;
        r.status = ST_OK;
        r.slot   = '0;
        case (op)
            OP_APPEND, OP_PREPEND, OP_INSERT: begin
                if (v == '0 || (op == OP_INSERT && lst_val[at] == '0)) begin
                    r.status = ST_BAD;
                end else if (lst_free >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    n                       = lst_free;
                    lst_free                = lst_nxt[n[SLOT_W-1:0]];
                    lst_val[n[SLOT_W-1:0]]  = v;
                    lst_cnt++;
                    if (op == OP_APPEND) begin
                        lst_prv[n[SLOT_W-1:0]] = lst_tail;
                        lst_nxt[n[SLOT_W-1:0]] = NIL_LINK;
                        if (lst_tail < DEPTH) lst_nxt[lst_tail[SLOT_W-1:0]] = n;
                        else lst_head = n;
                        lst_tail = n;
                    end else if (op == OP_PREPEND) begin
                        lst_prv[n[SLOT_W-1:0]] = NIL_LINK;
                        lst_nxt[n[SLOT_W-1:0]] = lst_head;
                        if (lst_head < DEPTH) lst_prv[lst_head[SLOT_W-1:0]] = n;
                        else lst_tail = n;
                        lst_head = n;
                    end else begin
                        nx                     = lst_nxt[at];
                        lst_prv[n[SLOT_W-1:0]] = t_link'(at);
                        lst_nxt[n[SLOT_W-1:0]] = nx;
                        if (nx < DEPTH) lst_prv[nx[SLOT_W-1:0]] = n;
                        else lst_tail = n;
                        lst_nxt[at] = n;
                    end
                    r.slot = n[SLOT_W-1:0];
                end
            end
            OP_REMOVE_AT: begin
                if (lst_val[at] == '0) begin
                    r.status = ST_BAD;
                end else begin
                    free_slot(at);
                    r.slot = at;
                end
            end
            OP_REMOVE_VAL, OP_FIND: begin
                hit = NIL_LINK;
                if (v != '0) begin
                    for (int s = DEPTH - 1; s >= 0; s--) begin
                        if (lst_val[t_slot'(s)] == v) hit = t_link'(s);
                    end
                end
                if (hit >= DEPTH) begin
                    r.status = ST_MISS;
                end else begin
                    if (op == OP_REMOVE_VAL) free_slot(hit[SLOT_W-1:0]);
                    r.slot = hit[SLOT_W-1:0];
                end
            end
            OP_CLEAR: begin
                list_reset();
            end
            default: begin
            end
        endcase
        r.count = lst_cnt;
        r.head  = (lst_cnt != 0 && lst_head < DEPTH) ? lst_head[SLOT_W-1:0] : '0;
        r.tail  = (lst_cnt != 0 && lst_tail < DEPTH) ? lst_tail[SLOT_W-1:0] : '0;
        return r;
    endfunction

    function automatic t_slot pick_slot();
        int occ;
        int k;
        occ = 0;
        for (int s = 0; s < DEPTH; s++) begin
            if (lst_val[t_slot'(s)] != '0) occ++;
        end
        if (occ != 0 && $urandom_range(99) < 75) begin
            k = $urandom_range(occ - 1);
            for (int s = 0; s < DEPTH; s++) begin
                if (lst_val[t_slot'(s)] != '0) begin
                    if (k == 0) return t_slot'(s);
                    k--;
                end
            end
        end
        return t_slot'($urandom_range(DEPTH - 1));
    endfunction

    function automatic t_value pick_value(bit nonzero);
        int     r;
        t_value v;
        r = $urandom_range(99);
        if (r < 50) v = t_value'($urandom_range(12, 1));
        else if (r < 68) v = t_value'($urandom());
        else if (r < 76) v = '1;
        else if (r < 86) v = lst_val[pick_slot()];
        else if (r < 93) v = {1'b1, 31'($urandom())};
        else v = '0;
        if (nonzero && v == '0) v = t_value'($urandom_range(12, 1));
        return v;
    endfunction

    function automatic t_list_cmd make_cmd(t_mix mix);
        int        r;
        t_list_cmd c;
        r = $urandom_range(99);
        case (mix)
            MIX_GROW: begin
                if (r < 85) c.op = t_opcode'($urandom_range(OP_INSERT, OP_APPEND));
                else c.op = t_opcode'($urandom_range(OP_FIND, OP_REMOVE_AT));
            end
            MIX_SHRINK: begin
                if (r < 75) c.op = ($urandom_range(1) != 0) ? OP_REMOVE_AT : OP_REMOVE_VAL;
                else if (r < 90) c.op = OP_FIND;
                else c.op = t_opcode'($urandom_range(OP_INSERT, OP_APPEND));
            end
            default: begin
                c.op = t_opcode'($urandom_range(OP_UNUSED, OP_APPEND));
                if (c.op == OP_CLEAR && $urandom_range(7) != 0) c.op = OP_FIND;
            end
        endcase
        c.value = pick_value(1'b0);
        c.slot  = pick_slot();
        return c;
    endfunction

    task automatic send_cmd(t_opcode op, t_value v, t_slot s);
        t_list_cmd c;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        c.op    = op;
        c.value = v;
        c.slot  = s;
        pending_cmds.push_back(c);
        if (op != OP_UNUSED) sent_cnt++;
    endtask

    task automatic note_mismatch(string msg);
        err_cnt++;
        if (err_cnt <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    function automatic bit quiet_window();
        return cyc >= 4000 && cyc < 8000;
    endfunction

    // Sender: one item on the wire at a time, payload held until accepted.
    always @(negedge i_clk) begin
        t_list_cmd c;
        if (i_rst_n) begin
            if (in_fire) begin
                reply_q.push_back(run_list_cmd(i_opcode, i_item_value, i_slot_index));
                accepted_cnt++;
            end
            if (!i_in_valid || in_fire) begin
                if (pending_cmds.size() != 0 &&
                    (quiet_window() || $urandom_range(99) >= 24)) begin
                    c = pending_cmds.pop_front();
                    i_in_valid   <= 1'b1;
                    i_opcode     <= c.op;
                    i_item_value <= c.value;
                    i_slot_index <= c.slot;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off) i_out_ready <= 1'b0;
        else i_out_ready <= quiet_window() || ($urandom_range(99) >= 24);
    end

    always @(posedge i_clk) begin
        t_list_reply want;
        cyc     <= cyc + 1;
        in_fire <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (reply_q.size() == 0) begin
                note_mismatch($sformatf("unexpected st=%0d slot=%0d cnt=%0d hd=%0d tl=%0d",
                              o_status, o_result_slot, o_element_count, o_head_slot,
                              o_tail_slot));
            end else begin
                want = reply_q.pop_front();
                if (o_status != want.status || o_result_slot != want.slot ||
                    o_element_count != want.count || o_head_slot != want.head ||
                    o_tail_slot != want.tail) begin
                    note_mismatch({
                        $sformatf("exp st=%0d slot=%0d cnt=%0d hd=%0d tl=%0d, ",
                                  want.status, want.slot, want.count, want.head,
                                  want.tail),
                        $sformatf("got st=%0d slot=%0d cnt=%0d hd=%0d tl=%0d",
                                  o_status, o_result_slot, o_element_count,
                                  o_head_slot, o_tail_slot)});
                end
            end
        end
    end

    // The receiver stops for a long stretch so the block backs up its input.
    initial begin
        while (accepted_cnt < 150) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("indexed_linked_list_manager_unit test failed");
        $finish;
    end

    initial begin
        int        phase;
        int        len;
        int        goal;
        t_mix      mix;
        t_list_cmd c;
        list_reset();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_cmd(OP_FIND, 32'd5, 6'd0);
        send_cmd(OP_REMOVE_AT, 32'd0, 6'd0);
        send_cmd(OP_REMOVE_VAL, 32'd5, 6'd0);
        send_cmd(OP_APPEND, 32'd0, 6'd0);
        send_cmd(OP_APPEND, 32'hFFFF_FFFF, 6'd63);
        send_cmd(OP_PREPEND, 32'd1, 6'd0);
        send_cmd(OP_INSERT, 32'h1234_5678, 6'd0);
        send_cmd(OP_INSERT, 32'hFFFF_FFFF, 6'd1);
        send_cmd(OP_INSERT, 32'd7, 6'd63);
        send_cmd(OP_INSERT, 32'd0, 6'd0);
        send_cmd(OP_PREPEND, 32'd0, 6'd0);
        send_cmd(OP_FIND, 32'hFFFF_FFFF, 6'd0);
        send_cmd(OP_FIND, 32'd0, 6'd63);
        send_cmd(OP_REMOVE_VAL, 32'hFFFF_FFFF, 6'd0);
        send_cmd(OP_FIND, 32'hFFFF_FFFF, 6'd0);
        send_cmd(OP_REMOVE_AT, 32'd0, 6'd0);
        send_cmd(OP_REMOVE_AT, 32'd0, 6'd1);
        send_cmd(OP_UNUSED, 32'd9, 6'd63);
        send_cmd(OP_REMOVE_AT, 32'd0, 6'd2);
        send_cmd(OP_APPEND, 32'h8000_0000, 6'd0);
        send_cmd(OP_REMOVE_VAL, 32'd0, 6'd0);
        send_cmd(OP_CLEAR, 32'hFFFF_FFFF, 6'd63);
        send_cmd(OP_REMOVE_AT, 32'd0, 6'd3);
        send_cmd(OP_APPEND, 32'h5555_5555, 6'd0);
        send_cmd(OP_CLEAR, 32'd0, 6'd0);

        goal  = sent_cnt + RANDOM_ITEMS;
        phase = 0;
        while (sent_cnt < goal) begin
            if (phase == 0 || phase == 5) begin
                // Fill the pool to the brim, then knock on it a few more times.
                while (lst_cnt < DEPTH) begin
                    send_cmd(t_opcode'($urandom_range(OP_INSERT, OP_APPEND)),
                             pick_value(1'b1), pick_slot());
                end
                repeat (3) begin
                    send_cmd(t_opcode'($urandom_range(OP_INSERT, OP_APPEND)),
                             pick_value(1'b1), pick_slot());
                end
            end else begin
                mix = t_mix'($urandom_range(MIX_ANY, MIX_GROW));
                len = $urandom_range(60, 10);
                repeat (len) begin
                    c = make_cmd(mix);
                    send_cmd(c.op, c.value, c.slot);
                end
            end
            phase++;
        end

        while (pending_cmds.size() != 0 || i_in_valid || reply_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (reply_q.size() != 0) note_mismatch($sformatf("%0d results never arrived",
                                                         reply_q.size()));
        if (err_cnt == 0) begin
            $display("indexed_linked_list_manager_unit test passed");
        end else begin
            $display("indexed_linked_list_manager_unit test failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/illm_pkg.sv
rtl/core/illm_link_store.sv
rtl/core/indexed_linked_list_manager_unit.sv
tb/sv/indexed_linked_list_manager_unit_tb.sv
